[rtl/crc_pkg.sv]
// Shared types and constants of the curl repetition counter.
// No dependencies; imported by every module of the block.
package crc_pkg;

  localparam int unsigned AngleW     = 9;
  localparam int unsigned SumW       = 10;
  localparam int unsigned AccelW     = 16;
  localparam int unsigned RunW       = 16;
  localparam int unsigned CountW     = 8;
  localparam int unsigned HoldW      = 7;
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned QueueDepth = 2;

  localparam logic [AngleW-1:0] HoldAngle   = AngleW'(30);
  localparam logic [AngleW-1:0] TroughStart = AngleW'(90);
  localparam logic [RunW-1:0]   HoldSamples = RunW'(100);

  localparam logic [AngleW-1:0] UpThresholdRst    = AngleW'(60);
  localparam logic [AngleW-1:0] DownThresholdRst  = AngleW'(30);
  localparam logic [AccelW-1:0] AccelLimitRst     = AccelW'(-100);
  localparam logic [RunW-1:0]   AccelRunLengthRst = RunW'(10);
  localparam logic [CountW-1:0] TargetRepsRst     = CountW'(10);

  typedef enum logic [CfgIndexW-1:0] {
    RegUpThreshold    = 3'd0,
    RegDownThreshold  = 3'd1,
    RegAccelLimit     = 3'd2,
    RegAccelRunLength = 3'd3,
    RegTargetReps     = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PhaseAwait  = 2'd0,
    PhaseHold   = 2'd1,
    PhaseCount  = 2'd2,
    PhaseTarget = 2'd3
  } phase_e;

  typedef struct packed {
    logic [SumW-1:0]   mag_sum;
    logic [AccelW-1:0] accel;
    logic              button;
  } sample_t;

  typedef struct packed {
    logic                 we;
    logic [CfgIndexW-1:0] index;
    logic [CfgDataW-1:0]  data;
  } cfg_wr_t;

endpackage

[rtl/crc_front.sv]
// Front end: accepts sensor beats and reduces orientation to |pitch|+|roll|.
// Depends on crc_pkg.
module crc_front (
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [crc_pkg::AngleW-1:0]      pitch_i,
  input  logic signed [crc_pkg::AngleW-1:0]      roll_i,
  input  logic signed [crc_pkg::AccelW-1:0]      vertical_accel_i,
  input  logic                                   button_i,
  output logic                                   push_o,
  input  logic                                   queue_full_i,
  output crc_pkg::sample_t                       sample_o
);
  import crc_pkg::*;

  logic [AngleW-1:0] mag_pitch;
  logic [AngleW-1:0] mag_roll;

  assign mag_pitch = pitch_i[AngleW-1] ? AngleW'(-pitch_i) : AngleW'(pitch_i);
  assign mag_roll  = roll_i[AngleW-1]  ? AngleW'(-roll_i)  : AngleW'(roll_i);

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  always_comb begin
    sample_o.mag_sum = {1'b0, mag_pitch} + {1'b0, mag_roll};
    sample_o.accel   = vertical_accel_i;
    sample_o.button  = button_i;
  end

endmodule

[rtl/crc_queue.sv]
// Short queue of reduced samples between the front and back ends.
// Depends on crc_pkg.
module crc_queue #(
  parameter int unsigned Depth = crc_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  crc_pkg::sample_t wdata_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output crc_pkg::sample_t rdata_o
);
  import crc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  sample_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[rtl/crc_back.sv]
// Back end: session state, rep detection, configuration registers and the
// registered result beat. Depends on crc_pkg.
module crc_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  crc_pkg::cfg_wr_t                  cfg_i,
  input  logic                              sample_valid_i,
  input  crc_pkg::sample_t                  sample_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        phase_o,
  output logic [crc_pkg::CountW-1:0]        rep_count_o,
  output logic                              rep_done_o,
  output logic [crc_pkg::AngleW-1:0]        rep_peak_o,
  output logic                              new_record_o,
  output logic [crc_pkg::HoldW-1:0]         hold_progress_o,
  output logic                              exit_pulse_o
);
  import crc_pkg::*;

  logic [AngleW-1:0] up_thr_q, down_thr_q;
  logic [AccelW-1:0] accel_limit_q;
  logic [RunW-1:0]   run_len_q;
  logic [CountW-1:0] target_q;

  logic              active_q, active_d;
  logic              calib_q, calib_d;
  logic              armed_q, armed_d;
  logic [AngleW-1:0] level_q, level_d;
  logic [RunW-1:0]   run_q, run_d;
  logic [CountW-1:0] reps_q, reps_d;
  logic [CountW-1:0] best_q, best_d;
  logic [AngleW-1:0] peak_q, peak_d;
  logic [AngleW-1:0] trough_q, trough_d;

  logic                 out_valid_q;
  phase_e               phase_q, phase_d;
  logic [CountW-1:0]    rep_count_q;
  logic                 rep_done_q, rep_done_d;
  logic [AngleW-1:0]    rep_peak_q, rep_peak_d;
  logic                 record_q, record_d;
  logic [HoldW-1:0]     hold_q, hold_d;
  logic                 exit_q, exit_d;

  logic signed [SumW:0] diff;
  logic [SumW:0]        diff_mag;
  logic [AngleW-1:0]    angle;
  logic [AngleW-1:0]    peak_new;
  logic [AngleW-1:0]    trough_base;
  logic [RunW-1:0]      run_inc;
  logic [CountW-1:0]    reps_inc;
  logic                 accel_low;

  assign pop_o = sample_valid_i && (!out_valid_q || out_ready_i);

  assign diff     = $signed({1'b0, sample_i.mag_sum}) - $signed({2'b00, level_q});
  assign diff_mag = diff[SumW] ? (SumW+1)'(-diff) : (SumW+1)'(diff);
  assign angle    = (diff_mag > (SumW+1)'({AngleW{1'b1}})) ? '1 : diff_mag[AngleW-1:0];
  assign peak_new = (angle > peak_q) ? angle : peak_q;
  assign run_inc  = (run_q == '1) ? run_q : run_q + 1'b1;
  assign reps_inc = reps_q + 1'b1;
  assign accel_low = $signed(sample_i.accel) < $signed(accel_limit_q);

  always_comb begin
    active_d    = active_q;
    calib_d     = calib_q;
    armed_d     = armed_q;
    level_d     = level_q;
    run_d       = run_q;
    reps_d      = reps_q;
    best_d      = best_q;
    peak_d      = peak_q;
    trough_d    = trough_q;
    trough_base = trough_q;
    rep_done_d  = 1'b0;
    rep_peak_d  = '0;
    record_d    = 1'b0;
    exit_d      = 1'b0;
    hold_d      = '0;

    if (!active_q) begin
      if (!calib_q) begin
        if (sample_i.button) begin
          level_d = angle;
          calib_d = 1'b1;
        end
      end else begin
        run_d = (angle <= HoldAngle) ? run_inc : '0;
        if (run_d >= HoldSamples) begin
          active_d = 1'b1;
          reps_d   = '0;
          run_d    = '0;
        end
      end
    end else if (reps_q < target_q && !sample_i.button) begin
      peak_d = peak_new;
      if (!armed_q) begin
        if (accel_low) begin
          run_d = run_inc;
          if (run_inc >= run_len_q && peak_new > up_thr_q) begin
            armed_d     = 1'b1;
            trough_base = TroughStart;
            run_d       = '0;
          end
        end else begin
          run_d = '0;
        end
      end else if (angle < down_thr_q && angle > trough_q) begin
        reps_d     = reps_inc;
        armed_d    = 1'b0;
        rep_done_d = 1'b1;
        rep_peak_d = peak_new;
        peak_d     = '0;
        if (reps_inc > best_q) begin
          best_d   = reps_inc;
          record_d = 1'b1;
        end
      end
      trough_d = (angle < trough_base) ? angle : trough_base;
    end else if (sample_i.button) begin
      active_d = 1'b0;
      reps_d   = '0;
      exit_d   = 1'b1;
    end

    if (!active_d) begin
      phase_d = calib_d ? PhaseHold : PhaseAwait;
    end else begin
      phase_d = (reps_d < target_q) ? PhaseCount : PhaseTarget;
    end
    if (phase_d == PhaseHold) begin
      hold_d = (run_d > HoldSamples) ? HoldW'(HoldSamples) : HoldW'(run_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_thr_q      <= UpThresholdRst;
      down_thr_q    <= DownThresholdRst;
      accel_limit_q <= AccelLimitRst;
      run_len_q     <= AccelRunLengthRst;
      target_q      <= TargetRepsRst;
      active_q      <= 1'b0;
      calib_q       <= 1'b0;
      armed_q       <= 1'b0;
      level_q       <= '0;
      run_q         <= '0;
      reps_q        <= '0;
      best_q        <= '0;
      peak_q        <= '0;
      trough_q      <= TroughStart;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_i.we) begin
        case (cfg_reg_e'(cfg_i.index))
          RegUpThreshold:    up_thr_q      <= cfg_i.data[AngleW-1:0];
          RegDownThreshold:  down_thr_q    <= cfg_i.data[AngleW-1:0];
          RegAccelLimit:     accel_limit_q <= cfg_i.data[AccelW-1:0];
          RegAccelRunLength: run_len_q     <= cfg_i.data[RunW-1:0];
          RegTargetReps:     target_q      <= cfg_i.data[CountW-1:0];
          default: ;
        endcase
      end
      if (pop_o) begin
        active_q    <= active_d;
        calib_q     <= calib_d;
        armed_q     <= armed_d;
        level_q     <= level_d;
        run_q       <= run_d;
        reps_q      <= reps_d;
        best_q      <= best_d;
        peak_q      <= peak_d;
        trough_q    <= trough_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      phase_q     <= phase_d;
      rep_count_q <= reps_d;
      rep_done_q  <= rep_done_d;
      rep_peak_q  <= rep_peak_d;
      record_q    <= record_d;
      hold_q      <= hold_d;
      exit_q      <= exit_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign phase_o         = phase_q;
  assign rep_count_o     = rep_count_q;
  assign rep_done_o      = rep_done_q;
  assign rep_peak_o      = rep_peak_q;
  assign new_record_o    = record_q;
  assign hold_progress_o = hold_q;
  assign exit_pulse_o    = exit_q;

endmodule

[rtl/curl_repetition_counter_unit.sv]
// Top level of the curl repetition counter: front end, sample queue, back end.
// Depends on crc_pkg, crc_front, crc_queue and crc_back.
//
// Takes one orientation/acceleration sample per cycle while the result side
// does not stall and returns one result beat per sample, in order. A sample's
// result passes from the queue into the output register of the back end; the
// sustained rate is one sample per cycle, set by the back end, which updates
// its state for each sample that it pops.
// Input ready drops only when the queue is full, which happens when the result
// side stalls. Configuration writes are always taken at once and are meant for
// an idle block; writes to indexes past the last register are ignored.
module curl_repetition_counter_unit #(
  parameter int unsigned QueueDepth = crc_pkg::QueueDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [crc_pkg::CfgIndexW-1:0]       cfg_index_i,
  input  logic [crc_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [crc_pkg::AngleW-1:0]   pitch_i,
  input  logic signed [crc_pkg::AngleW-1:0]   roll_i,
  input  logic signed [crc_pkg::AccelW-1:0]   vertical_accel_i,
  input  logic                                button_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          phase_o,
  output logic [crc_pkg::CountW-1:0]          rep_count_o,
  output logic                                rep_done_o,
  output logic [crc_pkg::AngleW-1:0]          rep_peak_o,
  output logic                                new_record_o,
  output logic [crc_pkg::HoldW-1:0]           hold_progress_o,
  output logic                                exit_pulse_o
);
  import crc_pkg::*;

  sample_t front_sample, queue_sample;
  cfg_wr_t cfg_wr;
  logic    push, queue_full, queue_valid, pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_wr.we    = cfg_valid_i;
    cfg_wr.index = cfg_index_i;
    cfg_wr.data  = cfg_data_i;
  end

  crc_front u_front (
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .pitch_i          (pitch_i),
    .roll_i           (roll_i),
    .vertical_accel_i (vertical_accel_i),
    .button_i         (button_i),
    .push_o           (push),
    .queue_full_i     (queue_full),
    .sample_o         (front_sample)
  );

  crc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_sample),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .pop_i   (pop),
    .rdata_o (queue_sample)
  );

  crc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_wr),
    .sample_valid_i  (queue_valid),
    .sample_i        (queue_sample),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .phase_o         (phase_o),
    .rep_count_o     (rep_count_o),
    .rep_done_o      (rep_done_o),
    .rep_peak_o      (rep_peak_o),
    .new_record_o    (new_record_o),
    .hold_progress_o (hold_progress_o),
    .exit_pulse_o    (exit_pulse_o)
  );

endmodule
